[hw/rtl/dis_pkg.sv]
// shared types, constants and helpers for the distinct index sampler
package dis_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 134;
  localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int LIMIT_W    = 20;
  localparam int WORD_W     = 32;
  localparam int CMD_W      = 2;
  localparam int READ_SLOT_W = 8;
  localparam int FILLED_W   = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(24646);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_OFFER  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SCAN   = 3'd1,
    ST_TAIL   = 3'd2,
    ST_RDWAIT = 3'd3,
    ST_DONE   = 3'd4
  } state_t;

  // one table entry as read from the store
  typedef struct packed {
    logic               valid;
    logic [LIMIT_W-1:0] data;
  } entry_t;

  // write request into the store
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
    logic [LIMIT_W-1:0] data;
  } store_wr_t;

  // all ones up to and including the highest set bit of v
  function automatic logic [LIMIT_W-1:0] length_mask(input logic [LIMIT_W-1:0] v);
    logic [LIMIT_W-1:0] m;
    m = '0;
    for (int i = 0; i < LIMIT_W; i++) begin
      m[i] = |(v >> i);
    end
    return m;
  endfunction

endpackage

[hw/rtl/dis_slot_store.sv]
// index table memory with per-slot valid bits and a registered read port
module dis_slot_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  dis_pkg::store_wr_t         wr,
  input  logic [dis_pkg::SLOT_W-1:0] rd_addr,
  output dis_pkg::entry_t            rd_entry
);
  import dis_pkg::*;

  logic [LIMIT_W-1:0]       mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  // data array without reset, read port registered with its valid flag
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_entry.data <= mem[rd_addr];
    if (rst) begin
      rd_entry.valid <= 1'b0;
    end else begin
      rd_entry.valid <= valid[rd_addr];
    end
  end

  // valid bits, an invalid slot reads as empty
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

endmodule

[hw/rtl/distinct_index_sampler_core.sv]
// top level of the distinct index sampler: sequencer, scan datapath and output register
// One item is taken at a time; the next can be accepted while the previous result still
// waits in the output register. An offer reads every table slot through the single read
// port of the slot store, one slot per cycle, then writes back; the block takes its next
// item once the result has moved into the output register. A clear empties the table at
// once through per-slot valid bits, and reset does the same, so no clearing pass is
// needed. index_limit may only be written while idle.
module distinct_index_sampler_core (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [dis_pkg::LIMIT_W-1:0]     cfg_wr_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dis_pkg::CMD_W-1:0]       cmd,
  input  logic [dis_pkg::WORD_W-1:0]      random_word,
  input  logic [dis_pkg::READ_SLOT_W-1:0] read_slot,
  // output channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dis_pkg::WORD_W-1:0]      slot_value,
  output logic [dis_pkg::FILLED_W-1:0]    filled_count,
  output logic                            accepted,
  output logic                            duplicate,
  output logic                            table_full
);
  import dis_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

  state_t             state, state_next;
  cmd_t               cmd_in;
  logic [LIMIT_W-1:0] index_limit;
  logic [LIMIT_W-1:0] idx_q;
  logic               read_oor;
  logic [SLOT_W-1:0]  scan_addr;
  logic               cmp_pend;
  logic               dup_q;
  logic [CNT_W-1:0]   fill_count;
  logic [WORD_W-1:0]  res_value;
  logic               res_acc;
  logic               res_dup;

  logic               in_beat;
  logic               slot_in_range;
  logic               hit;
  logic               dup_all;
  logic               not_full;
  logic               in_limit;
  logic               acc_now;
  logic               out_load;

  logic               store_clear;
  store_wr_t          store_wr;
  logic [SLOT_W-1:0]  store_rd_addr;
  entry_t             store_rd;

  dis_slot_store u_store (
    .clk      (clk),
    .rst      (rst),
    .clear    (store_clear),
    .wr       (store_wr),
    .rd_addr  (store_rd_addr),
    .rd_entry (store_rd)
  );

  // handshake and compare terms
  assign cmd_in        = cmd_t'(cmd);
  assign in_ready      = (state == ST_IDLE);
  assign in_beat       = in_valid && in_ready;
  assign slot_in_range = {1'b0, read_slot} < FILLED_W'(TABLE_ENTRIES);
  assign hit           = cmp_pend && store_rd.valid && (store_rd.data == idx_q);
  assign dup_all       = dup_q || hit;
  assign not_full      = fill_count < CNT_W'(TABLE_ENTRIES);
  assign in_limit      = idx_q < index_limit;
  assign acc_now       = in_limit && !dup_all;
  assign out_load      = (state == ST_DONE) && (!out_valid || out_ready);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      index_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      index_limit <= cfg_wr_data;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and store controls
  always_comb begin
    state_next    = state;
    store_clear   = 1'b0;
    store_wr      = '0;
    store_rd_addr = scan_addr;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          case (cmd_in)
            CMD_CLEAR: begin
              store_clear = 1'b1;
              state_next  = ST_DONE;
            end
            CMD_OFFER: begin
              store_rd_addr = '0;
              state_next    = ST_SCAN;
            end
            CMD_READ: begin
              store_rd_addr = slot_in_range ? read_slot[SLOT_W-1:0] : '0;
              state_next    = ST_RDWAIT;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_addr == LAST_SLOT) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        store_wr.en   = not_full;
        store_wr.addr = fill_count[SLOT_W-1:0];
        store_wr.data = idx_q;
        state_next    = ST_DONE;
      end
      ST_RDWAIT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // compare pipeline flag: read data of a scanned slot arrives in the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend <= 1'b0;
    end else begin
      cmp_pend <= (state == ST_SCAN);
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (in_beat && cmd_in == CMD_CLEAR) begin
      fill_count <= '0;
    end else if (state == ST_TAIL && acc_now && not_full) begin
      fill_count <= fill_count + CNT_W'(1);
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_beat) begin
      idx_q     <= random_word[LIMIT_W-1:0] & length_mask(index_limit);
      read_oor  <= !slot_in_range;
      scan_addr <= '0;
      dup_q     <= 1'b0;
      res_value <= '0;
      res_acc   <= 1'b0;
      res_dup   <= 1'b0;
    end else begin
      case (state)
        ST_SCAN: begin
          if (scan_addr != LAST_SLOT) begin
            scan_addr <= scan_addr + SLOT_W'(1);
          end
          if (hit) begin
            dup_q <= 1'b1;
          end
        end
        ST_TAIL: begin
          res_value <= WORD_W'(idx_q);
          res_dup   <= dup_all;
          res_acc   <= acc_now;
        end
        ST_RDWAIT: begin
          res_value <= (read_oor || !store_rd.valid) ? '1 : WORD_W'(store_rd.data);
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot_value   <= res_value;
      filled_count <= FILLED_W'(fill_count);
      accepted     <= res_acc;
      duplicate    <= res_dup;
      table_full   <= (fill_count == CNT_W'(TABLE_ENTRIES));
    end
  end

`ifndef SYNTH
  // count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  // a new index is never also a duplicate
  a_acc_dup: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && duplicate))
    else $error("result both accepted and duplicate");

  // the store is written only at the end of an offer scan, inside the table
  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    store_wr.en |-> (state == ST_TAIL && $past(state) == ST_SCAN && not_full))
    else $error("store write outside offer write-back");

  // count moves only by one at write-back or back to zero on clear
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (fill_count != $past(fill_count)) |->
      (fill_count == '0 || ($past(state) == ST_TAIL &&
       fill_count == $past(fill_count) + CNT_W'(1))))
    else $error("unexpected fill count change");
`endif

endmodule
